@@ src/gds_pkg.sv @@
// shared constants, command/status types and calendar helpers for the date stepper
package gds_pkg;

  localparam int COUNT_BITS = 16;
  localparam int YEAR_BITS  = 16;

  localparam int CNT_EXT_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int CMP_BITS     = (YEAR_BITS > 16) ? YEAR_BITS : 16;

  // year / 400 by reciprocal multiply, exact over the whole year range
  localparam int RECIP_SHIFT = YEAR_BITS + 9;
  localparam int RECIP_BITS  = YEAR_BITS + 1;
  localparam int PROD_BITS   = YEAR_BITS + RECIP_BITS;
  localparam int QUOT_BITS   = YEAR_BITS - 8;
  localparam logic [RECIP_BITS-1:0] RECIP_400 =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd399) / 64'd400);

  localparam logic [15:0]          FLOOR_YEAR_RESET = 16'd1900;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX         = {YEAR_BITS{1'b1}};

  localparam logic [9:0] QUAD_CENT = 10'd400;
  localparam logic [8:0] CENT_1    = 9'd100;
  localparam logic [8:0] CENT_2    = 9'd200;
  localparam logic [8:0] CENT_3    = 9'd300;
  localparam logic [8:0] REM_TOP   = 9'd399;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  localparam logic [4:0] LEN_28 = 5'd28;
  localparam logic [4:0] LEN_29 = 5'd29;
  localparam logic [4:0] LEN_30 = 5'd30;
  localparam logic [4:0] LEN_31 = 5'd31;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic check;
    logic step;
    logic publish;
  } gds_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic date_ok;
    logic out_free;
  } gds_status_t;

  // leap test from the year modulo 400
  function automatic logic is_leap(input logic [8:0] rem);
    logic cent;
    cent = (rem == CENT_1) || (rem == CENT_2) || (rem == CENT_3);
    return (rem[1:0] == 2'b00) && !cent;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      MON_FEB: len = leap ? LEN_29 : LEN_28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_30;
      default: len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

@@ src/gds_datapath.sv @@
// date registers, year modulo unit, day step logic and output register
module gds_datapath import gds_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  gds_cmd_t          cmd,
  output gds_status_t       status,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  logic [4:0]        in_start_day,
  input  logic [3:0]        in_start_month,
  input  logic [15:0]       in_start_year,
  input  logic              in_go_back,
  input  logic [15:0]       in_day_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        out_day,
  output logic [3:0]        out_month,
  output logic [15:0]       out_year,
  output logic              out_date_valid
);

  logic [15:0]           floor_year_r;
  logic [4:0]            day_r, day_nxt;
  logic [3:0]            mon_r, mon_nxt;
  logic [YEAR_BITS-1:0]  year_r, year_nxt;
  logic [8:0]            rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic                  back_r;
  logic                  ok_r, ok_nxt;
  logic                  out_valid_r;
  logic [4:0]            out_day_r;
  logic [3:0]            out_mon_r;
  logic [15:0]           out_year_r;
  logic                  out_ok_r;

  logic [CMP_BITS-1:0]     year_in_ext;
  logic [CNT_EXT_BITS-1:0] cnt_in_ext;
  logic [PROD_BITS-1:0]    year_prod;
  logic [QUOT_BITS-1:0]    year_quot;
  logic [YEAR_BITS-1:0]    quot_scaled;
  logic [YEAR_BITS-1:0]    year_rem;
  logic                    leap;
  logic [4:0]              len_cur;
  logic [4:0]              len_prev;
  logic [3:0]              mon_prev;
  logic [YEAR_BITS-1:0]    year_dec;
  logic                    start_ok;
  logic [CMP_BITS-1:0]     out_year_ext;

  assign year_in_ext = CMP_BITS'(in_start_year);
  assign cnt_in_ext  = CNT_EXT_BITS'(in_day_count);

  // year modulo 400 in combinational logic: quotient by reciprocal, then subtract
  assign year_prod   = PROD_BITS'(year_r) * PROD_BITS'(RECIP_400);
  assign year_quot   = year_prod[RECIP_SHIFT +: QUOT_BITS];
  assign quot_scaled = YEAR_BITS'(year_quot) * YEAR_BITS'(QUAD_CENT);
  assign year_rem    = year_r - quot_scaled;

  assign leap     = is_leap(rem_r);
  assign len_cur  = month_len(mon_r, leap);
  assign mon_prev = mon_r - 4'd1;
  assign len_prev = month_len(mon_prev, leap);
  assign year_dec = year_r - YEAR_BITS'(1);

  assign start_ok = (mon_r >= MON_JAN) && (mon_r <= MON_DEC) && (day_r != 5'd0) &&
                    (day_r <= len_cur) && (CMP_BITS'(year_r) >= CMP_BITS'(floor_year_r));

  always_comb begin
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    rem_nxt  = rem_r;
    ok_nxt   = ok_r;
    if (cmd.mod_step) begin
      rem_nxt = year_rem[8:0];
    end else if (cmd.check) begin
      ok_nxt = start_ok;
    end else if (cmd.step) begin
      if (!back_r) begin
        if (day_r == len_cur) begin
          day_nxt = 5'd1;
          if (mon_r == MON_DEC) begin
            mon_nxt = MON_JAN;
            if (year_r == YEAR_MAX) begin
              year_nxt = '0;
              ok_nxt   = 1'b0;
            end else begin
              year_nxt = year_r + YEAR_BITS'(1);
              rem_nxt  = (rem_r == REM_TOP) ? 9'd0 : rem_r + 9'd1;
            end
          end else begin
            mon_nxt = mon_r + 4'd1;
          end
        end else begin
          day_nxt = day_r + 5'd1;
        end
      end else begin
        if (day_r == 5'd1) begin
          if (mon_r == MON_JAN) begin
            mon_nxt = MON_DEC;
            day_nxt = LEN_31;
            if (year_r == '0) begin
              year_nxt = YEAR_MAX;
              ok_nxt   = 1'b0;
            end else begin
              year_nxt = year_dec;
              rem_nxt  = (rem_r == 9'd0) ? REM_TOP : rem_r - 9'd1;
              if (CMP_BITS'(year_dec) < CMP_BITS'(floor_year_r)) begin
                ok_nxt = 1'b0;
              end
            end
          end else begin
            mon_nxt = mon_prev;
            day_nxt = len_prev;
          end
        end else begin
          day_nxt = day_r - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_year_r <= FLOOR_YEAR_RESET;
    end else if (cfg_wr_en) begin
      floor_year_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_r  <= in_start_day;
      mon_r  <= in_start_month;
      year_r <= year_in_ext[YEAR_BITS-1:0];
      rem_r  <= '0;
      cnt_r  <= cnt_in_ext[COUNT_BITS-1:0];
      back_r <= in_go_back;
      ok_r   <= 1'b0;
    end else begin
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
      rem_r  <= rem_nxt;
      ok_r   <= ok_nxt;
      if (cmd.step) begin
        cnt_r <= cnt_r - COUNT_BITS'(1);
      end
    end
  end

  // output register frees the walk for the next item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_year_ext = CMP_BITS'(year_r);

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_day_r  <= day_r;
      out_mon_r  <= mon_r;
      out_year_r <= out_year_ext[15:0];
      out_ok_r   <= ok_r;
    end
  end

  assign status.cnt_zero = (cnt_r == '0);
  assign status.date_ok  = ok_r;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_day        = out_day_r;
  assign out_month      = out_mon_r;
  assign out_year       = out_year_r;
  assign out_date_valid = out_ok_r;

endmodule

@@ src/gds_control.sv @@
// sequencer for load, year remainder, date check, day walk and hand-over
module gds_control import gds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gds_status_t status,
  output gds_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // a failed step clears the valid flag, which ends the walk
        if (status.cnt_zero || !status.date_ok) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/gregorian_date_day_stepper.sv @@
// top level: steps a gregorian date by a day count, one day per cycle
// the walk stops early if a step leaves the date invalid or below the year floor
// the sequencer finds the year modulo 400, then checks the date, then walks one day per cycle
// one item at a time: in_stall stays high until the result is handed to the output register
// reset: synchronous active-low rst_n, year floor returns to 1900, no item or result pending
module gregorian_date_day_stepper import gds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_start_day,
  input  logic [3:0]  in_start_month,
  input  logic [15:0] in_start_year,
  input  logic        in_go_back,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [15:0] out_year,
  output logic        out_date_valid
);

  gds_cmd_t    cmd;
  gds_status_t status;

  gds_control u_control (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gds_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_start_day   (in_start_day),
    .in_start_month (in_start_month),
    .in_start_year  (in_start_year),
    .in_go_back     (in_go_back),
    .in_day_count   (in_day_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_day        (out_day),
    .out_month      (out_month),
    .out_year       (out_year),
    .out_date_valid (out_date_valid)
  );

endmodule
